>>> src/assert_macros.svh
// Assertion macros used by the top level of the vector normalizer.
// Depends on nothing; the user supplies the clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/v3n_pkg.sv
// Package of the vector normalizer: constants and the structs passed between stages.
// Depends on nothing; the square root, the divider lane and the top level import it.
package v3n_pkg;

    localparam int SqrtSteps = 32;
    localparam int DivSteps  = 32;

    localparam logic [15:0] MinMagReset = 16'd7;
    localparam logic [2:0]  RegMinMag   = 3'd0;

    localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
    localparam logic [31:0] SatNeg = 32'h8000_0000;

    // Per-component data that rides alongside the square root.
    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
    } side_t;

    // Operands handed to one divider lane.
    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
        logic [31:0] divisor;
        logic        zero;
    } div_in_t;

endpackage

>>> src/v3n_if.sv
// Stream interfaces of the vector normalizer: input vectors and normalized results.
// Depends on nothing.
interface v3n_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface v3n_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic               magnitude_clamped;

    modport source (output valid, output x_out, output y_out, output z_out,
                    output magnitude_clamped, input ready);
    modport sink   (input valid, input x_out, input y_out, input z_out,
                    input magnitude_clamped, output ready);
endinterface

>>> src/v3n_sqrt.sv
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// Depends on v3n_pkg for the stage count and the side data struct.
module v3n_sqrt (
    input  logic           clk,
    input  logic           en,
    input  logic [63:0]    n_in,
    input  v3n_pkg::side_t side_in,
    output logic [31:0]    root_out,
    output v3n_pkg::side_t side_out
);
    import v3n_pkg::*;

    logic [63:0] n_reg    [SqrtSteps];
    logic [63:0] root_reg [SqrtSteps];
    side_t       side_reg [SqrtSteps];

    for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
        localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
        logic [63:0] cur_n;
        logic [63:0] cur_root;
        side_t       cur_side;
        logic [63:0] trial;

        if (k == 0) begin : g_first
            assign cur_n    = n_in;
            assign cur_root = 64'd0;
            assign cur_side = side_in;
        end
        else begin : g_rest
            assign cur_n    = n_reg[k-1];
            assign cur_root = root_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        assign trial = cur_root + Bit;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cur_n >= trial)
                begin
                    n_reg[k]    <= cur_n - trial;
                    root_reg[k] <= (cur_root >> 1) + Bit;
                end
                else
                begin
                    n_reg[k]    <= cur_n;
                    root_reg[k] <= cur_root >> 1;
                end
                side_reg[k] <= cur_side;
            end
        end
    end

    assign root_out = root_reg[SqrtSteps-1][31:0];
    assign side_out = side_reg[SqrtSteps-1];

endmodule

>>> src/v3n_div_lane.sv
// One divider lane: (mag << 30) / divisor, restoring, one quotient bit per stage,
// then sign and Q2.30 saturation. Depends on v3n_pkg.
module v3n_div_lane (
    input  logic             clk,
    input  logic             en,
    input  v3n_pkg::div_in_t din,
    output logic [31:0]      quot
);
    import v3n_pkg::*;

    logic [31:0] rem_reg [DivSteps+1];
    logic [31:0] lo_reg  [DivSteps+1];
    logic [31:0] q_reg   [DivSteps+1];
    logic [31:0] d_reg   [DivSteps+1];
    logic        neg_reg [DivSteps+1];
    logic        ovf_reg [DivSteps+1];
    logic        zero_reg[DivSteps+1];
    logic [31:0] quot_reg;

    // The quotient overflows 32 bits exactly when the upper dividend word reaches the divisor.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {2'b00, din.mag[31:2]};
            lo_reg[0]   <= {din.mag[1:0], 30'd0};
            q_reg[0]    <= 32'd0;
            d_reg[0]    <= din.divisor;
            neg_reg[0]  <= din.neg;
            zero_reg[0] <= din.zero;
            ovf_reg[0]  <= ({2'b00, din.mag[31:2]} >= din.divisor);
        end
    end

    for (genvar k = 0; k < DivSteps; k++) begin : g_step
        logic [32:0] trial;
        logic [32:0] diff;
        logic        ge;

        assign trial = {rem_reg[k], lo_reg[k][31]};
        assign diff  = trial - {1'b0, d_reg[k]};
        assign ge    = (trial >= {1'b0, d_reg[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? diff[31:0] : trial[31:0];
                lo_reg[k+1]   <= {lo_reg[k][30:0], 1'b0};
                q_reg[k+1]    <= {q_reg[k][30:0], ge};
                d_reg[k+1]    <= d_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            priority if (zero_reg[DivSteps])
                quot_reg <= 32'd0;
            else if (ovf_reg[DivSteps] || q_reg[DivSteps][31])
                quot_reg <= neg_reg[DivSteps] ? SatNeg : SatPos;
            else if (neg_reg[DivSteps])
                quot_reg <= 32'd0 - q_reg[DivSteps];
            else
                quot_reg <= q_reg[DivSteps];
        end
    end

    assign quot = quot_reg;

endmodule

>>> src/vector3_normalize.sv
// Top level of the 3D vector normalizer: APB register, stream ports, lane pipelines.
// Depends on v3n_pkg, v3n_if, v3n_sqrt, v3n_div_lane and assert_macros.svh.

// The block takes one vector of three signed Q16.16 components per transaction and
// returns one transaction per vector: the components divided by the vector's length,
// as signed Q2.30 with saturation, and a flag that is set when the floor square root
// of x*x + y*y + z*z fell below min_magnitude and that minimum was used instead. A
// new vector is accepted every clock cycle while the pipeline is not halted. Most of
// the pipeline is the square root, which settles one result bit per stage over
// 32 stages, and the three divider lanes, which settle one quotient bit per stage
// over 32 stages. When the output holds an untaken result, stages still drain into
// empty slots; the pipeline, and with it input ready, halts only when a result waits
// at its last stage. min_magnitude sits at APB byte address 0 and resets to 7
// (about 0.0001).
`include "assert_macros.svh"

module vector3_normalize (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    v3n_in_if.sink      vin,
    v3n_out_if.source   vout
);
    import v3n_pkg::*;

    // Three front stages (abs, square, sum), the root, the clamp, the divider lanes.
    localparam int Lat = 3 + SqrtSteps + 1 + DivSteps + 2;

    logic [15:0] min_reg;

    logic [Lat-1:0] vld_reg;
    logic           en;

    side_t            side_s0_reg;
    side_t            side_s1_reg;
    side_t            side_s2_reg;
    logic [2:0][63:0] sq_reg;
    logic [63:0]      sum_reg;

    logic [31:0] root;
    side_t       side_root;

    logic [31:0] mag_clamp;
    logic        clamp_now;
    div_in_t     div_in_reg [3];
    logic        clamped_reg;
    logic        clamp_pipe [DivSteps+2];
    logic [31:0] quot [3];

    logic        out_valid_reg;
    logic [31:0] x_out_reg;
    logic [31:0] y_out_reg;
    logic [31:0] z_out_reg;
    logic        clamped_out_reg;

    // Configuration: one register, written on the APB access cycle.
    assign pready = 1'b1;
    assign prdata = (paddr == RegMinMag) ? {16'd0, min_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_reg <= MinMagReset;
        else if (psel && penable && pwrite && pready && (paddr == RegMinMag))
            min_reg <= pwdata[15:0];
    end

    // The pipeline moves unless a finished result is stuck behind an untaken output.
    assign en        = !out_valid_reg || vout.ready || !vld_reg[Lat-1];
    assign vin.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Lat-2:0], vin.valid};
    end

    // Stage 0: magnitude and sign of each component. The most negative value maps to 2^31.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_s0_reg.neg[0] <= vin.x_in[31];
            side_s0_reg.neg[1] <= vin.y_in[31];
            side_s0_reg.neg[2] <= vin.z_in[31];
            side_s0_reg.mag[0] <= vin.x_in[31] ? 32'd0 - vin.x_in : vin.x_in;
            side_s0_reg.mag[1] <= vin.y_in[31] ? 32'd0 - vin.y_in : vin.y_in;
            side_s0_reg.mag[2] <= vin.z_in[31] ? 32'd0 - vin.z_in : vin.z_in;
        end
    end

    // Stage 1: one 32x32 squarer per lane. Stage 2: the lanes merge into one sum,
    // which cannot exceed 3 * 2^62 and so fits 64 bits.
    for (genvar i = 0; i < 3; i++) begin : g_sq
        always_ff @(posedge clk)
        begin
            if (en)
                sq_reg[i] <= {32'd0, side_s0_reg.mag[i]} * {32'd0, side_s0_reg.mag[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_s1_reg <= side_s0_reg;
            side_s2_reg <= side_s1_reg;
            sum_reg     <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    v3n_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .n_in     (sum_reg),
        .side_in  (side_s2_reg),
        .root_out (root),
        .side_out (side_root)
    );

    // Clamp stage: the divisor is the larger of the root and the minimum magnitude.
    assign clamp_now = (root < {16'd0, min_reg});
    assign mag_clamp = clamp_now ? {16'd0, min_reg} : root;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_in_reg[i].mag     <= side_root.mag[i];
                div_in_reg[i].neg     <= side_root.neg[i];
                div_in_reg[i].divisor <= mag_clamp;
                div_in_reg[i].zero    <= (mag_clamp == 32'd0);
            end
        end

        v3n_div_lane u_div (
            .clk  (clk),
            .en   (en),
            .din  (div_in_reg[i]),
            .quot (quot[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
            clamped_reg <= clamp_now;
    end

    // The clamp flag follows the divider lanes stage for stage.
    for (genvar k = 0; k < DivSteps + 2; k++) begin : g_flag
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (k == 0)
                    clamp_pipe[k] <= clamped_reg;
                else
                    clamp_pipe[k] <= clamp_pipe[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Output register: loads when the last stage holds a result and the pipeline moves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en && vld_reg[Lat-1])
            out_valid_reg <= 1'b1;
        else if (vout.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[Lat-1])
        begin
            x_out_reg       <= quot[0];
            y_out_reg       <= quot[1];
            z_out_reg       <= quot[2];
            clamped_out_reg <= clamp_pipe[DivSteps+1];
        end
    end

    assign vout.valid             = out_valid_reg;
    assign vout.x_out             = x_out_reg;
    assign vout.y_out             = y_out_reg;
    assign vout.z_out             = z_out_reg;
    assign vout.magnitude_clamped = clamped_out_reg;

    // An accepted transaction occupies the first stage on the next cycle.
    `ASSERT_NEXT(a_accept_enters, clk, rst_n, vin.valid && vin.ready, vld_reg[0])
    // While the pipeline is halted no stage gains or loses a transaction.
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, !en, $stable(vld_reg))
    // A halt happens only with a result waiting both at the output and at the last stage.
    `ASSERT_SAME(a_stall_cause, clk, rst_n, !vin.ready, out_valid_reg && vld_reg[Lat-1])

endmodule
